>>> design/sfcd_pkg.sv
// Shared types, constants and the CRC-8 function of the sensor frame CRC decoder.
package sfcd_pkg;

  localparam int unsigned FrameBytes = 24;
  localparam int unsigned WordCount  = 8;
  localparam int unsigned PosW       = 5;
  localparam int unsigned GroupW     = 3;
  localparam int unsigned QuotW      = 13;

  localparam logic [PosW-1:0]   LastPos = PosW'(FrameBytes - 1);
  localparam logic [7:0]        CrcPoly = 8'h31;
  localparam logic [7:0]        CrcInit = 8'hFF;

  // Reciprocals: q = (w * m) >> k, exact for every 16-bit w
  localparam logic [16:0] RecipTen     = 17'd52429;  // 2^19 / 10, rounded up
  localparam logic [16:0] RecipHundred = 17'd83887;  // 2^23 / 100 and 2^24 / 200

  // Word slots with a divisor other than ten
  localparam logic [GroupW-1:0] GrpHumidity    = 3'd4;
  localparam logic [GroupW-1:0] GrpTemperature = 3'd5;

  // Place of a byte inside its three-byte group
  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

  // Word tracker to scaler and output stage
  typedef struct packed {
    logic              wr_en;
    logic [GroupW-1:0] group;
    logic [15:0]       word;
    logic              last;
    logic              ok;
  } trk_t;

  typedef logic [WordCount-1:0][QuotW-1:0] quot_arr_t;

  typedef struct packed {
    logic        frame_ok;
    logic [12:0] pm1_value;
    logic [12:0] pm2_5_value;
    logic [12:0] pm4_value;
    logic [12:0] pm10_value;
    logic [9:0]  humidity_value;
    logic [8:0]  temperature_value;
    logic [12:0] voc_value;
    logic [12:0] nox_value;
  } result_t;

  // CRC-8, polynomial 0x31, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/sfcd_if.sv
// Handshake channel interfaces for reply bytes and decoded frame results.
interface sfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfcd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [12:0] pm1_value;
  logic [12:0] pm2_5_value;
  logic [12:0] pm4_value;
  logic [12:0] pm10_value;
  logic [9:0]  humidity_value;
  logic [8:0]  temperature_value;
  logic [12:0] voc_value;
  logic [12:0] nox_value;

  modport source (output valid, output frame_ok, output pm1_value, output pm2_5_value,
                  output pm4_value, output pm10_value, output humidity_value,
                  output temperature_value, output voc_value, output nox_value,
                  input ready);
  modport sink   (input valid, input frame_ok, input pm1_value, input pm2_5_value,
                  input pm4_value, input pm10_value, input humidity_value,
                  input temperature_value, input voc_value, input nox_value,
                  output ready);
endinterface

>>> design/sensor_frame_crc_decoder_unit.sv
// Top level of the sensor frame CRC decoder: input register, tracker, scaler, result register.
//
//   channel  | dir | payload                                  | handshake
//   in_if    | in  | data_byte[7:0], frame_start              | valid/ready
//   out_if   | out | frame_ok, eight scaled sensor values     | valid/ready
//
// One byte per cycle sustained while the result register can take a frame. A byte
// is held in the input register, where CRC, word assembly and the single
// reciprocal multiplier act on it. The 24th byte of a frame loads the result
// register as it leaves the input register; out_if then shows the frame's result.
// Synchronous active-low reset clears position, CRC, fail flag and valids.
// A stalled result only blocks the last byte of the next frame.
module sensor_frame_crc_decoder_unit import sfcd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  sfcd_in_if.sink    in_if,
  sfcd_out_if.source out_if
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       out_valid_r;
  result_t    res_r, res_nxt;

  trk_t      trk;
  quot_arr_t quot;
  logic      out_free;
  logic      adv;

  // Advance a held byte unless it ends a frame and the result slot is full
  assign out_free    = !out_valid_r || out_if.ready;
  assign adv         = in_valid_r && (!trk.last || out_free);
  assign in_if.ready = !in_valid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r  <= in_if.data_byte;
      in_start_r <= in_if.frame_start;
    end
  end

  sfcd_byte_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .data_byte   (in_byte_r),
    .frame_start (in_start_r),
    .trk         (trk)
  );

  sfcd_word_scale u_scale (
    .clk  (clk),
    .adv  (adv),
    .trk  (trk),
    .quot (quot)
  );

  // Zero every value on a failed frame
  always_comb begin
    res_nxt = '0;
    res_nxt.frame_ok = trk.ok;
    if (trk.ok) begin
      res_nxt.pm1_value         = quot[0];
      res_nxt.pm2_5_value       = quot[1];
      res_nxt.pm4_value         = quot[2];
      res_nxt.pm10_value        = quot[3];
      res_nxt.humidity_value    = quot[4][9:0];
      res_nxt.temperature_value = quot[5][8:0];
      res_nxt.voc_value         = quot[6];
      res_nxt.nox_value         = quot[7];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && trk.last) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && trk.last) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.frame_ok          = res_r.frame_ok;
  assign out_if.pm1_value         = res_r.pm1_value;
  assign out_if.pm2_5_value       = res_r.pm2_5_value;
  assign out_if.pm4_value         = res_r.pm4_value;
  assign out_if.pm10_value        = res_r.pm10_value;
  assign out_if.humidity_value    = res_r.humidity_value;
  assign out_if.temperature_value = res_r.temperature_value;
  assign out_if.voc_value         = res_r.voc_value;
  assign out_if.nox_value         = res_r.nox_value;

endmodule

>>> design/sfcd_byte_track.sv
// Frame position, per-group CRC check and big-endian word assembly.
module sfcd_byte_track import sfcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  output trk_t       trk
);

  logic [PosW-1:0]   pos_r, pos_nxt;
  phase_t            phase_r, phase_nxt;
  logic [GroupW-1:0] group_r, group_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic              fail_r, fail_nxt;

  logic              restart;
  logic [PosW-1:0]   pos_eff;
  phase_t            phase_eff;
  logic [GroupW-1:0] group_eff;
  logic              fail_eff;
  logic              crc_bad;
  logic              last;
  logic              wr_en;

  // Drop a partial frame on a start flag
  assign restart   = frame_start || (pos_r > LastPos);
  assign pos_eff   = restart ? '0 : pos_r;
  assign phase_eff = restart ? PH_HIGH : phase_r;
  assign group_eff = restart ? '0 : group_r;
  assign fail_eff  = restart ? 1'b0 : fail_r;
  assign crc_bad   = (crc_r != data_byte);
  assign last      = (pos_eff == LastPos);

  // Next state for one byte
  always_comb begin
    pos_nxt   = pos_eff + PosW'(1);
    phase_nxt = phase_eff;
    group_nxt = group_eff;
    crc_nxt   = crc_r;
    hold_nxt  = hold_r;
    fail_nxt  = fail_eff;
    wr_en     = 1'b0;
    case (phase_eff)
      PH_HIGH: begin
        hold_nxt  = data_byte;
        crc_nxt   = crc8_byte(CrcInit, data_byte);
        phase_nxt = PH_LOW;
      end
      PH_LOW: begin
        crc_nxt   = crc8_byte(crc_r, data_byte);
        wr_en     = 1'b1;
        phase_nxt = PH_CRC;
      end
      PH_CRC: begin
        fail_nxt  = fail_eff || crc_bad;
        crc_nxt   = CrcInit;
        phase_nxt = PH_HIGH;
        group_nxt = group_eff + GroupW'(1);
      end
      default: begin
        phase_nxt = PH_HIGH;
      end
    endcase
    // Close the frame after its last byte
    if (last) begin
      pos_nxt   = '0;
      phase_nxt = PH_HIGH;
      group_nxt = '0;
      crc_nxt   = CrcInit;
      fail_nxt  = 1'b0;
    end
  end

  assign trk.wr_en = wr_en;
  assign trk.group = group_eff;
  assign trk.word  = {hold_r, data_byte};
  assign trk.last  = last;
  assign trk.ok    = !(fail_eff || crc_bad);

  // Advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HIGH;
      group_r <= '0;
      crc_r   <= CrcInit;
      hold_r  <= '0;
      fail_r  <= 1'b0;
    end else if (adv) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      group_r <= group_nxt;
      crc_r   <= crc_nxt;
      hold_r  <= hold_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

>>> design/sfcd_word_scale.sv
// Divides each assembled word by its constant and keeps the eight quotients.
module sfcd_word_scale import sfcd_pkg::*; (
  input  logic      clk,
  input  logic      adv,
  input  trk_t      trk,
  output quot_arr_t quot
);

  logic [16:0]      recip;
  logic [32:0]      prod;
  logic [QuotW-1:0] q;
  quot_arr_t        quot_r;

  // Pick reciprocal and shift by word slot
  always_comb begin
    case (trk.group)
      GrpHumidity:    recip = RecipHundred;
      GrpTemperature: recip = RecipHundred;
      default:        recip = RecipTen;
    endcase
  end

  assign prod = 33'(trk.word) * 33'(recip);

  always_comb begin
    case (trk.group)
      GrpHumidity:    q = QuotW'(prod[32:23]);
      GrpTemperature: q = QuotW'(prod[32:24]);
      default:        q = prod[31:19];
    endcase
  end

  // Store the quotient when the low byte lands
  always_ff @(posedge clk) begin
    if (adv && trk.wr_en) begin
      quot_r[trk.group] <= q;
    end
  end

  assign quot = quot_r;

endmodule

>>> dv/sensor_frame_crc_decoder_unit_test.sv
// Self-checking test of the sensor frame CRC decoder: byte stimulus, frame prediction, result check.
module sensor_frame_crc_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfcd_pkg::*;

  localparam int unsigned TotalBytes  = 1650;
  localparam int unsigned LimitCycles = 1000000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned LongHold    = 400;

  // Predicts one decoded frame per completed 24-byte frame and checks results in order
  class frame_decode_board;
    logic [4:0]  byte_pos;
    logic [7:0]  crc_acc;
    logic [7:0]  high_hold;
    logic [15:0] words [WordCount];
    logic        any_bad;
    result_t     pending_frames [$];
    int unsigned mismatch_count;
    int unsigned frames_checked;

    function new();
      byte_pos  = '0;
      crc_acc   = CrcInit;
      high_hold = '0;
      any_bad   = 1'b0;
      foreach (words[i]) words[i] = '0;
      mismatch_count = 0;
      frames_checked = 0;
    endfunction

    // CRC-8 over one byte, polynomial 0x31, MSB first
    static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
    endfunction

    // Advance the frame tracker by one accepted byte; queue a result on the last byte
    function void take_byte(logic [7:0] b, logic st);
      logic [4:0] pos;
      phase_t     ph;
      logic [2:0] grp;
      result_t    r;
      pos = byte_pos;
      if (st || pos > LastPos) begin
        pos     = '0;
        any_bad = 1'b0;
      end
      ph  = phase_t'(2'(pos % 3));
      grp = 3'(pos / 3);
      case (ph)
        PH_HIGH: begin
          high_hold = b;
          crc_acc   = crc_step(CrcInit, b);
        end
        PH_LOW: begin
          crc_acc     = crc_step(crc_acc, b);
          words[grp]  = {high_hold, b};
        end
        default: begin
          if (crc_acc != b) any_bad = 1'b1;
          crc_acc = CrcInit;
        end
      endcase
      if (pos == LastPos) begin
        r = '0;
        r.frame_ok = !any_bad;
        if (!any_bad) begin
          r.pm1_value         = 13'(words[0] / 16'd10);
          r.pm2_5_value       = 13'(words[1] / 16'd10);
          r.pm4_value         = 13'(words[2] / 16'd10);
          r.pm10_value        = 13'(words[3] / 16'd10);
          r.humidity_value    = 10'(words[4] / 16'd100);
          r.temperature_value = 9'(words[5] / 16'd200);
          r.voc_value         = 13'(words[6] / 16'd10);
          r.nox_value         = 13'(words[7] / 16'd10);
        end
        pending_frames.push_back(r);
        byte_pos = '0;
        crc_acc  = CrcInit;
        any_bad  = 1'b0;
      end else begin
        byte_pos = pos + 5'd1;
      end
    endfunction

    task report(string msg);
      if (mismatch_count < 50) $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    task cmp(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    // Compare one accepted result against the oldest predicted frame
    task check_frame(result_t got);
      result_t want;
      if (pending_frames.size() == 0) begin
        report("result with no frame pending");
        return;
      end
      want = pending_frames.pop_front();
      cmp("frame_ok", 16'(got.frame_ok), 16'(want.frame_ok));
      cmp("pm1_value", 16'(got.pm1_value), 16'(want.pm1_value));
      cmp("pm2_5_value", 16'(got.pm2_5_value), 16'(want.pm2_5_value));
      cmp("pm4_value", 16'(got.pm4_value), 16'(want.pm4_value));
      cmp("pm10_value", 16'(got.pm10_value), 16'(want.pm10_value));
      cmp("humidity_value", 16'(got.humidity_value), 16'(want.humidity_value));
      cmp("temperature_value", 16'(got.temperature_value), 16'(want.temperature_value));
      cmp("voc_value", 16'(got.voc_value), 16'(want.voc_value));
      cmp("nox_value", 16'(got.nox_value), 16'(want.nox_value));
      frames_checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  sfcd_in_if  in_if ();
  sfcd_out_if out_if ();

  sensor_frame_crc_decoder_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  frame_decode_board sb;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  bit          sender_calm;
  result_t     seen_frame;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bias words toward the ends of the range and toward divisor boundaries
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF - 16'($urandom_range(0, 3));
      1:       return 16'($urandom_range(0, 255));
      2:       return 16'($urandom_range(0, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one byte, hold it until accepted, then note it for prediction
  task automatic send_byte(input logic [7:0] b, input logic st);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.frame_start <= st;
    do @(posedge clk); while (!in_if.ready);
    sb.take_byte(b, st);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the first len bytes of a frame; set bits of bad spoil that group's CRC byte
  task automatic send_frame(input logic [15:0] w [WordCount], input logic st,
                            input logic [7:0] bad, input int unsigned len);
    int unsigned g;
    logic [7:0]  crc;
    logic [7:0]  b;
    for (int unsigned i = 0; i < len; i++) begin
      g = i / 3;
      case (i % 3)
        0:       b = w[g][15:8];
        1:       b = w[g][7:0];
        default: begin
          crc = frame_decode_board::crc_step(
                  frame_decode_board::crc_step(CrcInit, w[g][15:8]), w[g][7:0]);
          b = crc ^ (bad[g] ? 8'($urandom_range(1, 255)) : 8'h00);
        end
      endcase
      send_byte(b, (i == 0) ? st : 1'b0);
    end
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    logic [15:0] w [WordCount];
    int unsigned kind;
    logic        st;
    bit          aligned;
    sb = new();
    bytes_sent        = 0;
    sender_calm       = 1'b0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.frame_start = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Partial frame, then a restart with extreme words
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    w = '{16'hFFFF, 16'h0000, 16'h0009, 16'h000A, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFE};
    send_frame(w, 1'b1, 8'h00, FrameBytes);
    aligned = 1'b1;

    // Mostly well-formed frames, some bad CRCs, cut frames and loose bytes
    while (bytes_sent < TotalBytes) begin
      kind = $urandom_range(0, 99);
      foreach (w[g]) w[g] = pick_word();
      sender_calm = ($urandom_range(0, 4) == 0);
      st = aligned ? ($urandom_range(0, 3) != 0) : 1'b1;
      if (kind < 60) begin
        send_frame(w, st, 8'h00, FrameBytes);
        aligned = 1'b1;
      end else if (kind < 76) begin
        send_frame(w, st, 8'($urandom_range(1, 255)), FrameBytes);
        aligned = 1'b1;
      end else if (kind < 88) begin
        send_frame(w, st, 8'h00, $urandom_range(1, FrameBytes - 1));
        aligned = 1'b0;
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
        aligned = 1'b0;
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("sensor_frame_crc_decoder_unit_test: PASS");
    end else begin
      $display("sensor_frame_crc_decoder_unit_test: FAIL");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches, and one long hold-off
  initial begin : receiver
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned hold_left;
    bit          held_once;
    stall_left   = 0;
    calm_left    = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_once && sb.frames_checked >= 4) begin
        hold_left = LongHold;
        held_once = 1'b1;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 99) < 30) begin
          stall_left = pick_gap();
        end else if ($urandom_range(0, 99) < 5) begin
          calm_left = $urandom_range(20, 100);
        end
      end
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_frame.frame_ok          = out_if.frame_ok;
      seen_frame.pm1_value         = out_if.pm1_value;
      seen_frame.pm2_5_value       = out_if.pm2_5_value;
      seen_frame.pm4_value         = out_if.pm4_value;
      seen_frame.pm10_value        = out_if.pm10_value;
      seen_frame.humidity_value    = out_if.humidity_value;
      seen_frame.temperature_value = out_if.temperature_value;
      seen_frame.voc_value         = out_if.voc_value;
      seen_frame.nox_value         = out_if.nox_value;
      sb.check_frame(seen_frame);
    end
  end

  // Stop a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("sensor_frame_crc_decoder_unit_test: FAIL");
      $finish;
    end
  end

endmodule

>>> sensor_frame_crc_decoder_unit.f
design/sfcd_pkg.sv
design/sfcd_if.sv
design/sfcd_byte_track.sv
design/sfcd_word_scale.sv
design/sensor_frame_crc_decoder_unit.sv
dv/sensor_frame_crc_decoder_unit_test.sv
